>>> hdl/fdc_pkg.sv
// Shared types, constants and the CRC-16/KERMIT byte update for the frame decoder.
// No dependencies; used by fdc_rx, fdc_readout and the top level.
package fdc_pkg;

  // Frame geometry
  localparam int PAYLOAD_BYTES = 57;
  localparam int FRAME_LEN     = PAYLOAD_BYTES + 7;
  localparam int POS_W         = $clog2(FRAME_LEN);
  localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam pos_t POS_DATA      = POS_W'(4);
  localparam pos_t POS_BODY_LAST = POS_W'(PAYLOAD_BYTES + 3);
  localparam pos_t POS_CHECK_LO  = POS_W'(PAYLOAD_BYTES + 4);
  localparam pos_t POS_CHECK_HI  = POS_W'(PAYLOAD_BYTES + 5);
  localparam pos_t POS_END       = POS_W'(PAYLOAD_BYTES + 6);
  localparam idx_t IDX_LAST      = IDX_W'(PAYLOAD_BYTES - 1);

  // Reflected form of polynomial 0x1021
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_MARKER = 2'd0;
  localparam logic [1:0] CFG_END_MARKER   = 2'd1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BOUNDARY = 2'd1,
    STAT_LENGTH   = 2'd2,
    STAT_CRC      = 2'd3
  } status_t;

  // End-of-frame event from the receiver to the readout sequencer
  typedef struct packed {
    logic        done;
    status_t     status;
    logic [7:0]  cmd;
    logic [7:0]  node;
    logic [5:0]  len;
  } frame_evt_t;

  // One byte of CRC-16/KERMIT, LSB first
  function automatic logic [15:0] crc_kermit_byte(input logic [15:0] crc_in,
                                                  input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/frame_decoder_crc16_check_top.sv
// Top level of the fixed-length frame decoder with CRC-16/KERMIT check.
// Depends on fdc_pkg, fdc_ram, fdc_rx and fdc_readout.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  input    | in_valid/in_ready   | rx_byte, restart
//  result   | out_valid/out_ready | status, command_byte, node_byte,
//           |                     | payload_length, data_index, data_byte, last
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One byte is taken per cycle while a frame is received. The end byte of a good
// frame starts a readout of 57 results, one per cycle while out_ready holds,
// paced by the single read port of the payload RAM; input is held off until it
// finishes. A bad frame gives one result at once. The end byte waits while an
// earlier result sits unread. Reset is synchronous; the payload RAM needs no
// clearing pass. Config writes are always taken.
module frame_decoder_crc16_check_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       restart,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [7:0] command_byte,
  output logic [7:0] node_byte,
  output logic [5:0] payload_length,
  output logic [5:0] data_index,
  output logic [7:0] data_byte,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic                start_marker;
  logic [7:0]          start_mark;
  logic [7:0]          end_mark;
  logic                accept;
  logic                at_end;
  logic                busy;
  logic                wr_en;
  fdc_pkg::idx_t       wr_addr;
  logic [7:0]          wr_data;
  logic                rd_en;
  fdc_pkg::idx_t       rd_addr;
  logic [7:0]          rd_data;
  fdc_pkg::frame_evt_t evt;

  // Configuration registers
  assign cfg_ready    = 1'b1;
  assign start_marker = cfg_valid && (cfg_index == fdc_pkg::CFG_START_MARKER);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_mark <= '0;
      end_mark   <= '0;
    end else if (start_marker) begin
      start_mark <= cfg_data;
    end else if (cfg_valid && cfg_index == fdc_pkg::CFG_END_MARKER) begin
      end_mark <= cfg_data;
    end
  end

  // Input flow control: held during readout, and the end byte waits for an empty slot
  assign in_ready = !busy && !(out_valid && at_end);
  assign accept   = in_valid && in_ready;

  fdc_rx u_rx (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .rx_byte      (rx_byte),
    .restart      (restart),
    .start_marker (start_mark),
    .end_marker   (end_mark),
    .at_end       (at_end),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .evt          (evt)
  );

  fdc_ram #(
    .WIDTH (8),
    .DEPTH (fdc_pkg::PAYLOAD_BYTES)
  ) u_payload_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  fdc_readout u_readout (
    .clk            (clk),
    .rst            (rst),
    .evt            (evt),
    .busy           (busy),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .command_byte   (command_byte),
    .node_byte      (node_byte),
    .payload_length (payload_length),
    .data_index     (data_index),
    .data_byte      (data_byte),
    .last           (last)
  );

endmodule

>>> hdl/fdc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/fdc_rx.sv
// Frame receiver: byte position tracking, CRC-16/KERMIT, header capture,
// payload writes into the RAM and the end-of-frame verdict. Uses fdc_pkg.
module fdc_rx (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                rx_byte,
  input  logic                      restart,
  input  logic [7:0]                start_marker,
  input  logic [7:0]                end_marker,
  output logic                      at_end,
  output logic                      wr_en,
  output fdc_pkg::idx_t             wr_addr,
  output logic [7:0]                wr_data,
  output fdc_pkg::frame_evt_t       evt
);

  localparam int POS_W = fdc_pkg::POS_W;

  fdc_pkg::pos_t byte_position;
  fdc_pkg::pos_t pos;
  logic [15:0]   running_crc;
  logic          start_ok;
  logic          crc_ok;
  logic [7:0]    hdr_cmd;
  logic [7:0]    hdr_node;
  logic [7:0]    hdr_len;
  logic [7:0]    chk_lo;
  fdc_pkg::pos_t wr_off;

  // Effective position of this byte
  always_comb begin
    pos = restart ? '0 : byte_position;
    if ((POS_W+1)'(pos) >= (POS_W+1)'(fdc_pkg::FRAME_LEN)) begin
      pos = '0;
    end
  end

  assign at_end = (byte_position == fdc_pkg::POS_END);

  // Payload bytes go straight to the store
  assign wr_off  = pos - fdc_pkg::POS_DATA;
  assign wr_en   = accept && (pos >= fdc_pkg::POS_DATA) && (pos <= fdc_pkg::POS_BODY_LAST);
  assign wr_addr = wr_off[fdc_pkg::IDX_W-1:0];
  assign wr_data = rx_byte;

  // Verdict on the end byte: boundary, then length, then checksum
  always_comb begin
    evt.done = accept && (pos == fdc_pkg::POS_END);
    evt.cmd  = hdr_cmd;
    evt.node = hdr_node;
    evt.len  = hdr_len[5:0];
    if (!start_ok || rx_byte != end_marker) begin
      evt.status = fdc_pkg::STAT_BOUNDARY;
    end else if (hdr_len > 8'(fdc_pkg::PAYLOAD_BYTES)) begin
      evt.status = fdc_pkg::STAT_LENGTH;
    end else if (!crc_ok) begin
      evt.status = fdc_pkg::STAT_CRC;
    end else begin
      evt.status = fdc_pkg::STAT_OK;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_crc   <= '0;
      start_ok      <= 1'b0;
      crc_ok        <= 1'b0;
      hdr_cmd       <= '0;
      hdr_node      <= '0;
      hdr_len       <= '0;
      chk_lo        <= '0;
    end else if (accept) begin
      if (pos == '0) begin
        start_ok    <= (rx_byte == start_marker);
        running_crc <= '0;
      end else if (pos <= fdc_pkg::POS_BODY_LAST) begin
        running_crc <= fdc_pkg::crc_kermit_byte(running_crc, rx_byte);
        if (pos == POS_W'(1)) begin
          hdr_cmd <= rx_byte;
        end else if (pos == POS_W'(2)) begin
          hdr_node <= rx_byte;
        end else if (pos == POS_W'(3)) begin
          hdr_len <= rx_byte;
        end
      end else if (pos == fdc_pkg::POS_CHECK_LO) begin
        chk_lo <= rx_byte;
      end else if (pos == fdc_pkg::POS_CHECK_HI) begin
        // compare now so the high check byte need not be kept
        crc_ok <= (running_crc == {rx_byte, chk_lo});
      end
      byte_position <= (pos == fdc_pkg::POS_END) ? '0 : pos + POS_W'(1);
    end
  end

endmodule

>>> hdl/fdc_readout.sv
// Readout sequencer: walks the payload RAM after a good frame and drives the
// result register; also loads single error results. Uses fdc_pkg.
module fdc_readout (
  input  logic                 clk,
  input  logic                 rst,
  input  fdc_pkg::frame_evt_t  evt,
  output logic                 busy,
  output logic                 rd_en,
  output fdc_pkg::idx_t        rd_addr,
  input  logic [7:0]           rd_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [7:0]           command_byte,
  output logic [7:0]           node_byte,
  output logic [5:0]           payload_length,
  output logic [5:0]           data_index,
  output logic [7:0]           data_byte,
  output logic                 last
);

  logic          iss_active;
  fdc_pkg::idx_t iss_idx;
  logic          f_valid;
  fdc_pkg::idx_t f_idx;
  logic          f_adv;
  logic [7:0]    hdr_cmd;
  logic [7:0]    hdr_node;
  logic [5:0]    hdr_len;
  logic          good;
  logic          bad;

  assign good  = evt.done && (evt.status == fdc_pkg::STAT_OK);
  assign bad   = evt.done && (evt.status != fdc_pkg::STAT_OK);
  assign f_adv = f_valid && (!out_valid || out_ready);
  assign rd_en = iss_active && (!f_valid || f_adv);
  assign rd_addr = iss_idx;
  assign busy  = iss_active || f_valid;

  // Read issue and fetch stage (the RAM output register)
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_active <= 1'b0;
      iss_idx    <= '0;
      f_valid    <= 1'b0;
      f_idx      <= '0;
    end else begin
      if (good) begin
        iss_active <= 1'b1;
        iss_idx    <= '0;
      end else if (rd_en) begin
        iss_idx <= iss_idx + fdc_pkg::IDX_W'(1);
        if (iss_idx == fdc_pkg::IDX_LAST) begin
          iss_active <= 1'b0;
        end
      end
      if (rd_en) begin
        f_valid <= 1'b1;
        f_idx   <= iss_idx;
      end else if (f_adv) begin
        f_valid <= 1'b0;
      end
    end
  end

  // Header of the frame being read out
  always_ff @(posedge clk) begin
    if (good) begin
      hdr_cmd  <= evt.cmd;
      hdr_node <= evt.node;
      hdr_len  <= evt.len;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (f_adv || bad) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bad) begin
      status         <= evt.status;
      command_byte   <= '0;
      node_byte      <= '0;
      payload_length <= '0;
      data_index     <= '0;
      data_byte      <= '0;
      last           <= 1'b1;
    end else if (f_adv) begin
      status         <= fdc_pkg::STAT_OK;
      command_byte   <= hdr_cmd;
      node_byte      <= hdr_node;
      payload_length <= hdr_len;
      data_index     <= 6'(f_idx);
      data_byte      <= rd_data;
      last           <= (f_idx == fdc_pkg::IDX_LAST);
    end
  end

  // A frame verdict only arrives with the readout idle and the result slot empty
  a_evt_idle: assert property (@(posedge clk) disable iff (rst)
    evt.done |-> (!busy && !out_valid))
    else $error("frame verdict while readout busy");

  // No new read may overwrite RAM data still waiting in the fetch stage
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !f_adv) |-> !rd_en)
    else $error("RAM read while fetch stage stalled");

  // While reads are still issuing, the fetch stage never holds the final index
  a_order: assert property (@(posedge clk) disable iff (rst)
    (f_valid && iss_active) |-> (f_idx != fdc_pkg::IDX_LAST))
    else $error("readout index order broken");

  // Once the final result is taken, the sequencer is idle
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> !busy)
    else $error("readout still busy after final result");

endmodule
